>>> src/rc4_stream_cipher_core_defines.svh
// Assertion helpers for the RC4 engine.
`ifndef RC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_STREAM_CIPHER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RC4_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc4 check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc4 check failed");

`endif

>>> src/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 9;
   localparam int PERM_DEPTH  = 256;
   localparam int PERM_AW     = 8;
   localparam int KEY_DEPTH   = 256;
   localparam int KEY_AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [PERM_AW-1:0] perm_addr_type;
   typedef logic [KEY_AW-1:0]  key_addr_type;
   typedef logic [1:0]         action_type;

   localparam action_type ACT_LOAD_KEY = 2'd0;
   localparam action_type ACT_SCHEDULE = 2'd1;
   localparam action_type ACT_CRYPT    = 2'd2;

   localparam len_type       KEY_LEN_RESET = LEN_W'(16);
   localparam perm_addr_type PERM_LAST     = PERM_AW'(PERM_DEPTH - 1);
   localparam key_addr_type  KEY_LAST      = KEY_AW'(KEY_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD,
      ST_KS_SUM,
      ST_KS_WR_K,
      ST_KS_WR_A,
      ST_CR_RD_I,
      ST_CR_RD_J,
      ST_CR_WR_I,
      ST_CR_WR_J
   } rc4_state_type;

   typedef struct packed {
      rc4_state_type state;
      perm_addr_type k;
      logic          k_last;
   } rc4_ctrl_type;

endpackage

>>> src/rc4_if.sv
`timescale 1ns / 1ps

interface rc4_req_if import rc4_pkg::*;
();
   logic       valid;
   logic       ready;
   action_type action;
   byte_type   data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

interface rc4_csr_if import rc4_pkg::*;
();
   logic    valid;
   logic    ready;
   len_type key_length;

   modport source (output valid, output key_length, input ready);
   modport sink   (input valid, input key_length, output ready);
endinterface

>>> src/rc4_ram.sv
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/rc4_alu.sv
`timescale 1ns / 1ps

// Shared modulo-256 three-operand adder.
module rc4_alu import rc4_pkg::*;
(
   input  byte_type a,
   input  byte_type b,
   input  byte_type c,
   output byte_type sum
);

   logic [BYTE_W+1:0] wide;

   assign wide = {2'b00, a} + {2'b00, b} + {2'b00, c};
   assign sum  = wide[BYTE_W-1:0];

endmodule

>>> src/rc4_seq.sv
`timescale 1ns / 1ps

module rc4_seq import rc4_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  action_type   req_action,
   input  logic         rsp_free,
   output rc4_ctrl_type ctrl
);

   rc4_state_type state_ff, state_in;
   perm_addr_type k_ff, k_in;
   logic          k_last;

   assign k_last = (k_ff == PERM_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_SCHEDULE) begin
                  state_in = ST_INIT;
                  k_in     = '0;
               end else if (req_action == ACT_CRYPT) begin
                  state_in = ST_CR_RD_I;
               end
            end
         end
         ST_INIT: begin
            k_in = k_ff + 1'b1;
            if (k_last) begin
               state_in = ST_KS_RD;
            end
         end
         ST_KS_RD:   state_in = ST_KS_SUM;
         ST_KS_SUM:  state_in = ST_KS_WR_K;
         ST_KS_WR_K: state_in = ST_KS_WR_A;
         ST_KS_WR_A: begin
            k_in     = k_ff + 1'b1;
            state_in = k_last ? ST_IDLE : ST_KS_RD;
         end
         ST_CR_RD_I: state_in = ST_CR_RD_J;
         ST_CR_RD_J: state_in = ST_CR_WR_I;
         ST_CR_WR_I: state_in = ST_CR_WR_J;
         ST_CR_WR_J: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctrl.state  = state_ff;
   assign ctrl.k      = k_ff;
   assign ctrl.k_last = k_last;

endmodule

>>> src/rc4_stream_cipher_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                  Transfer when
// req_chan  in         action, data_byte        valid && ready
// rsp_chan  out        out_byte                 valid && ready
// csr_chan  in         key_length (9 bits)      valid && ready (ready tied high)
//
// Load-key: written at the transfer; ready stays high. Crypt: states CR_RD_I,
// CR_RD_J, CR_WR_I, CR_WR_J, set by the single read and single write port of
// the permutation RAM (two reads, swap write pair, keystream read overlapped).
// Schedule: 256 identity writes, then KS_RD, KS_SUM, KS_WR_K, KS_WR_A per
// entry on the same RAM ports. Reset clears indices, key write position,
// sequencer and result valid; key_length returns to 16. A stalled result is
// held in its output register while the next item is taken.

`include "rc4_stream_cipher_core_defines.svh"

module rc4_stream_cipher_core import rc4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   rc4_req_if.sink  req_chan,
   rc4_rsp_if.source rsp_chan,
   rc4_csr_if.sink  csr_chan
);

   rc4_ctrl_type ctrl;

   logic req_fire;
   logic rsp_free;

   // Architectural state
   byte_type     i_ff, i_in;
   byte_type     j_ff, j_in;
   key_addr_type key_pos_ff, key_pos_in;
   len_type      key_len_ff;

   // Working registers of the current item
   byte_type     acc_ff, acc_in;
   key_addr_type kk_ff, kk_in;
   byte_type     si_ff, si_in;
   byte_type     sj_ff, sj_in;
   byte_type     t_ff, t_in;
   byte_type     data_ff, data_in;

   // Result register
   logic         rsp_valid_ff;
   byte_type     rsp_byte_ff;
   logic         rsp_load;
   byte_type     keystream;

   // Permutation RAM
   logic          perm_we, perm_re;
   perm_addr_type perm_waddr, perm_raddr;
   byte_type      perm_wdata, perm_rdata;

   // Key store RAM
   logic          key_we, key_re;
   byte_type      key_rdata;

   // Shared adder
   byte_type      alu_a, alu_b, alu_c, alu_sum;

   len_type       key_last_idx;
   logic          kk_wrap;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (ctrl.state == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;

   rc4_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_action (req_chan.action),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl)
   );

   rc4_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .sum (alu_sum)
   );

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
      .clock (clock),
      .we    (perm_we),
      .waddr (perm_waddr),
      .wdata (perm_wdata),
      .re    (perm_re),
      .raddr (perm_raddr),
      .rdata (perm_rdata)
   );

   assign key_we = req_fire && (req_chan.action == ACT_LOAD_KEY);

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_pos_ff),
      .wdata (req_chan.data_byte),
      .re    (key_re),
      .raddr (kk_ff),
      .rdata (key_rdata)
   );

   // Last key index used by the schedule: zero length counts as one,
   // lengths past the store saturate at its depth.
   always_comb begin
      if (key_len_ff == '0) begin
         key_last_idx = '0;
      end else if (key_len_ff > LEN_W'(KEY_DEPTH)) begin
         key_last_idx = LEN_W'(KEY_DEPTH - 1);
      end else begin
         key_last_idx = key_len_ff - 1'b1;
      end
   end

   assign kk_wrap = ({{(LEN_W - KEY_AW){1'b0}}, kk_ff} == key_last_idx);

   // Keystream byte after the swap: the entry just read may be one of the
   // two entries being swapped, so take the swapped value directly then.
   always_comb begin
      if (t_ff == j_ff) begin
         keystream = si_ff;
      end else if (t_ff == i_ff) begin
         keystream = sj_ff;
      end else begin
         keystream = perm_rdata;
      end
   end

   always_comb begin
      perm_we    = 1'b0;
      perm_waddr = ctrl.k;
      perm_wdata = ctrl.k;
      perm_re    = 1'b0;
      perm_raddr = ctrl.k;
      key_re     = 1'b0;
      alu_a      = '0;
      alu_b      = '0;
      alu_c      = '0;
      rsp_load   = 1'b0;
      i_in       = i_ff;
      j_in       = j_ff;
      key_pos_in = key_pos_ff;
      acc_in     = acc_ff;
      kk_in      = kk_ff;
      si_in      = si_ff;
      sj_in      = sj_ff;
      t_in       = t_ff;
      data_in    = data_ff;
      case (ctrl.state)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_LOAD_KEY: begin
                     // advance the write slot, wrapping over the store
                     key_pos_in = (key_pos_ff == KEY_LAST) ? '0 : key_pos_ff + 1'b1;
                  end
                  ACT_SCHEDULE: begin
                     acc_in = '0;
                     kk_in  = '0;
                  end
                  ACT_CRYPT: begin
                     data_in = req_chan.data_byte;
                  end
                  default: begin
                     // unused action: drop the item
                  end
               endcase
            end
         end
         ST_INIT: begin
            // identity fill, one entry a cycle
            perm_we = 1'b1;
         end
         ST_KS_RD: begin
            perm_re = 1'b1;
            key_re  = 1'b1;
         end
         ST_KS_SUM: begin
            alu_a      = acc_ff;
            alu_b      = perm_rdata;
            alu_c      = key_rdata;
            acc_in     = alu_sum;
            si_in      = perm_rdata;
            perm_re    = 1'b1;
            perm_raddr = alu_sum;
            kk_in      = kk_wrap ? '0 : kk_ff + 1'b1;
         end
         ST_KS_WR_K: begin
            perm_we    = 1'b1;
            perm_wdata = perm_rdata;
         end
         ST_KS_WR_A: begin
            perm_we    = 1'b1;
            perm_waddr = acc_ff;
            perm_wdata = si_ff;
            if (ctrl.k_last) begin
               i_in = '0;
               j_in = '0;
            end
         end
         ST_CR_RD_I: begin
            alu_a      = i_ff;
            alu_b      = 8'd1;
            i_in       = alu_sum;
            perm_re    = 1'b1;
            perm_raddr = alu_sum;
         end
         ST_CR_RD_J: begin
            alu_a      = j_ff;
            alu_b      = perm_rdata;
            j_in       = alu_sum;
            si_in      = perm_rdata;
            perm_re    = 1'b1;
            perm_raddr = alu_sum;
         end
         ST_CR_WR_I: begin
            alu_a      = si_ff;
            alu_b      = perm_rdata;
            sj_in      = perm_rdata;
            t_in       = alu_sum;
            perm_re    = 1'b1;
            perm_raddr = alu_sum;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rdata;
         end
         ST_CR_WR_J: begin
            // repeat the write while stalled; it is idempotent
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            rsp_load   = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         key_pos_ff   <= '0;
         key_len_ff   <= KEY_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff       <= i_in;
         j_ff       <= j_in;
         key_pos_ff <= key_pos_in;
         if (csr_chan.valid && csr_chan.ready) begin
            key_len_ff <= csr_chan.key_length;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      kk_ff   <= kk_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      data_ff <= data_in;
      if (rsp_load) begin
         rsp_byte_ff <= data_ff ^ keystream;
      end
   end

   `RC4_ASSERT_NEXT(a_crypt_starts, clock, reset,
      req_fire && (req_chan.action == ACT_CRYPT), ctrl.state == ST_CR_RD_I)
   `RC4_ASSERT_NEXT(a_sched_clears_idx, clock, reset,
      (ctrl.state == ST_KS_WR_A) && ctrl.k_last,
      (ctrl.state == ST_IDLE) && (i_ff == '0) && (j_ff == '0))
   `RC4_ASSERT_NEXT(a_result_lands, clock, reset,
      (ctrl.state == ST_CR_WR_J) && rsp_free, rsp_valid_ff && (ctrl.state == ST_IDLE))
   `RC4_ASSERT_NOW(a_no_load_outside_crypt, clock, reset,
      (ctrl.state != ST_CR_WR_J), !rsp_load)

endmodule

>>> sim/tb_rc4_stream_cipher_core.sv
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;
   import rc4_pkg::*;

   // Action code the block must ignore: no state change, no result.
   localparam action_type ACT_UNUSED = 2'd3;

   // A schedule gives no result, so hold the request side idle for longer than
   // a schedule runs before touching key_length or ending the run.
   localparam int SETTLE_CYCLES = 1400;
   localparam int MAX_REPORTS   = 10;

   logic clock;
   logic reset;

   // Set for the closing phase: no idling on either side.
   bit calm = 1'b0;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();
   rc4_csr_if csr_bus ();

   rc4_stream_cipher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Mirror of the cipher state, updated from observed transfers.
   byte_type     perm_mirror [PERM_DEPTH];
   byte_type     key_mirror [KEY_DEPTH];
   key_addr_type key_wr_ptr     = '0;
   byte_type     idx_i          = '0;
   byte_type     idx_j          = '0;
   len_type      key_len_shadow = KEY_LEN_RESET;
   byte_type     pending_cipher_bytes [$];

   // Stimulus bookkeeping: slots written so far (from slot 0 upwards) and
   // whether a schedule has been sent, so that no unwritten key slot and no
   // unscheduled permutation is ever read.
   int unsigned keys_loaded    = 0;
   bit          scheduled      = 1'b0;
   len_type     gen_key_length = KEY_LEN_RESET;

   int unsigned fault_count   = 0;
   int unsigned bytes_checked = 0;
   int unsigned n_loads       = 0;
   int unsigned n_schedules   = 0;
   int unsigned n_unused      = 0;
   int unsigned n_settings    = 0;

   byte_type want_byte;

   // 8 ns clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Zero is taken as one; anything past the key store saturates.
   function automatic int unsigned usable_key_length(len_type v);
      if (v == 0) return 1;
      if (v > KEY_DEPTH) return KEY_DEPTH;
      return v;
   endfunction

   // Identity fill, then the key-scheduling pass; clears both indices.
   function automatic void rebuild_permutation();
      int unsigned n;
      byte_type    acc;
      byte_type    t;
      n   = usable_key_length(key_len_shadow);
      acc = '0;
      for (int k = 0; k < PERM_DEPTH; k++) perm_mirror[k] = byte_type'(k);
      for (int k = 0; k < PERM_DEPTH; k++) begin
         acc              = acc + perm_mirror[k] + key_mirror[k % n];
         t                = perm_mirror[k];
         perm_mirror[k]   = perm_mirror[acc];
         perm_mirror[acc] = t;
      end
      idx_i = '0;
      idx_j = '0;
   endfunction

   // One generator step; returns the data byte XOR the keystream byte.
   function automatic byte_type keystream_xor(byte_type d);
      byte_type t;
      idx_i              = idx_i + 8'd1;
      idx_j              = idx_j + perm_mirror[idx_i];
      t                  = perm_mirror[idx_i];
      perm_mirror[idx_i] = perm_mirror[idx_j];
      perm_mirror[idx_j] = t;
      t = perm_mirror[byte_type'(perm_mirror[idx_i] + perm_mirror[idx_j])];
      return d ^ t;
   endfunction

   task automatic note_fault(string what, byte_type want, byte_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
   endtask

   // Monitor and checker. Check the result side before applying a request
   // taken on the same edge: a crypt transfer never yields its result on the
   // edge that accepts it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_cipher_bytes.size() == 0) begin
               note_fault("result with nothing outstanding", 8'h00, rsp_bus.out_byte);
            end else begin
               want_byte = pending_cipher_bytes.pop_front();
               bytes_checked++;
               if (rsp_bus.out_byte !== want_byte)
                  note_fault("out_byte mismatch", want_byte, rsp_bus.out_byte);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.action)
               ACT_LOAD_KEY: begin
                  key_mirror[key_wr_ptr] = req_bus.data_byte;
                  key_wr_ptr             = key_wr_ptr + 1'b1;
                  n_loads++;
               end
               ACT_SCHEDULE: begin
                  rebuild_permutation();
                  n_schedules++;
               end
               ACT_CRYPT: pending_cipher_bytes.push_back(keystream_xor(req_bus.data_byte));
               default: n_unused++;
            endcase
         end
         if (csr_bus.valid && csr_bus.ready) key_len_shadow = csr_bus.key_length;
      end
   end

   // Result back-pressure: random stalls between open stretches; hold ready
   // high throughout the calm phase.
   initial begin
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   // Send one item and return on the edge of its transfer. Keep valid high
   // into the next call unless a gap is taken, so that valid never gets two
   // assignments in one time step.
   task automatic send_item(action_type act, byte_type d);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.data_byte <= d;
      do @(posedge clock); while (!req_bus.ready);
      case (act)
         ACT_LOAD_KEY: if (keys_loaded < KEY_DEPTH) keys_loaded++;
         ACT_SCHEDULE: scheduled = 1'b1;
         default: ;
      endcase
   endtask

   // Drop valid, wait for every outstanding result, then let any schedule
   // still in flight run out.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_cipher_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_key_length(len_type v);
      settle_idle();
      csr_bus.valid      <= 1'b1;
      csr_bus.key_length <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid  <= 1'b0;
      gen_key_length  = v;
      n_settings++;
   endtask

   // Reset key length of 16: load sixteen bytes with both byte extremes,
   // schedule, crypt the extremes and slip in an unused action.
   task automatic test_default_key_length();
      for (int k = 0; k < 16; k++)
         send_item(ACT_LOAD_KEY, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF :
                                 byte_type'($urandom_range(0, 255)));
      send_item(ACT_SCHEDULE, 8'h00);
      send_item(ACT_CRYPT, 8'h00);
      send_item(ACT_CRYPT, 8'hFF);
      send_item(ACT_UNUSED, 8'hFF);
      send_item(ACT_CRYPT, 8'h5A);
   endtask

   // Key length zero behaves as a one-byte key.
   task automatic test_zero_key_length();
      set_key_length('0);
      send_item(ACT_SCHEDULE, 8'hFF);
      send_item(ACT_CRYPT, byte_type'($urandom_range(0, 255)));
      send_item(ACT_CRYPT, byte_type'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed sessions (keys, schedule, a burst of crypts) with
   // random content; the rest single noise items. Unused actions do not
   // count towards the budget.
   task automatic run_sessions(int unsigned budget);
      int unsigned sent;
      int unsigned eff;
      int unsigned nkeys;
      int unsigned run;
      sent = 0;
      while (sent < budget) begin
         eff = usable_key_length(gen_key_length);
         if ($urandom_range(0, 3) != 0) begin
            // Rekey fully for short keys; top up only what is missing for
            // long ones, since older slots stay valid after wrapping.
            nkeys = (eff <= 24) ? eff : $urandom_range(0, 6);
            if (keys_loaded + nkeys < eff) nkeys = eff - keys_loaded;
            repeat (nkeys) send_item(ACT_LOAD_KEY, byte_type'($urandom_range(0, 255)));
            send_item(ACT_SCHEDULE, byte_type'($urandom_range(0, 255)));
            run = $urandom_range(4, 40);
            repeat (run) send_item(ACT_CRYPT, byte_type'($urandom_range(0, 255)));
            sent += nkeys + 1 + run;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_item(ACT_LOAD_KEY, byte_type'($urandom_range(0, 255)));
               7: send_item(ACT_UNUSED, byte_type'($urandom_range(0, 255)));
               8: send_item((keys_loaded >= eff) ? ACT_SCHEDULE : ACT_LOAD_KEY,
                            byte_type'($urandom_range(0, 255)));
               default: send_item(scheduled ? ACT_CRYPT : ACT_LOAD_KEY,
                                  byte_type'($urandom_range(0, 255)));
            endcase
            if (req_bus.action != ACT_UNUSED) sent++;
         end
      end
   endtask

   // Walk key_length through its extremes, saturation and random values.
   task automatic test_key_length_sweep();
      set_key_length(9'd1);
      run_sessions(200);
      set_key_length(9'd256);
      run_sessions(250);
      set_key_length(9'd511);
      run_sessions(150);
      set_key_length(9'd257);
      run_sessions(100);
      set_key_length(len_type'($urandom_range(2, 255)));
      run_sessions(250);
      set_key_length('0);
      run_sessions(100);
      set_key_length(len_type'($urandom_range(0, 511)));
      run_sessions(200);
   endtask

   // Closing phase at full rate on both sides.
   task automatic test_steady_stream();
      set_key_length(KEY_LEN_RESET);
      calm = 1'b1;
      run_sessions(250);
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_LOAD_KEY;
      req_bus.data_byte  <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.key_length <= KEY_LEN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_key_length();
      test_zero_key_length();
      test_key_length_sweep();
      test_steady_stream();
      settle_idle();

      $display("Run covered %0d checked cipher bytes, %0d key loads and %0d key schedules",
               bytes_checked, n_loads, n_schedules);
      $display("over %0d key length settings, with %0d ignored unused actions; %0d faults.",
               n_settings, n_unused, fault_count);
      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #10_000_000;
      $display("Watchdog expired with %0d results outstanding", pending_cipher_bytes.size());
      $display("FAIL");
      $finish;
   end

endmodule

>>> rc4_stream_cipher_core.f
+incdir+src
src/rc4_pkg.sv
src/rc4_if.sv
src/rc4_ram.sv
src/rc4_alu.sv
src/rc4_seq.sv
src/rc4_stream_cipher_core.sv
sim/tb_rc4_stream_cipher_core.sv
